/* design/mfb_pkg.sv */
// Shared types and constants for the monochrome frame store.
package mfb_pkg;

   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 43;
   localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int STORE_BYTES   = (PIXEL_COUNT + 7) / 8;
   localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int PIX_W         = ADDR_W + 3;
   localparam int CSR_INDEX_W   = 2;

   typedef enum logic [1:0] {
      OP_GET   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_XOR_MODE     = 2'd0,
      CSR_REVERSE_MODE = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] column;
      logic [5:0] row;
      logic       pixel_value;
   } req_type;

   typedef struct packed {
      logic pixel_read;
      logic status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic sweep_load;
      logic commit;
      logic sweep_step;
      logic sweep_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_clear;
      logic sweep_last;
   } ctrl_status_type;

endpackage

/* design/mfb_ctrl.sv */
// Controller state machine: accept, pixel access and store sweep sequencing.
module mfb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  mfb_pkg::ctrl_status_type status_i,
   output mfb_pkg::ctrl_cmd_type    cmd_o,
   output logic                     busy
);
   import mfb_pkg::*;

   state_type state_ff, state_in;
   logic      report_ff, report_in;

   // Reset lands in a silent sweep that zeroes the store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         report_ff <= report_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      report_in = report_ff;
      cmd_o     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_o.load = 1'b1;
               if (status_i.req_is_clear) begin
                  cmd_o.sweep_load = 1'b1;
                  report_in        = 1'b1;
                  state_in         = ST_SWEEP;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            cmd_o.commit = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd_o.sweep_step = 1'b1;
            if (status_i.sweep_last) begin
               cmd_o.sweep_done = report_ff;
               report_in        = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* design/mfb_datapath.sv */
// Datapath: frame store memory, address math, pixel update, config and result registers.
module mfb_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  mfb_pkg::req_type         req_word,
   input  mfb_pkg::ctrl_cmd_type    cmd_i,
   output mfb_pkg::ctrl_status_type status_o,
   input  logic                     csr_valid,
   input  logic [mfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                     csr_data,
   output logic                     rsp_valid,
   output mfb_pkg::rsp_type         rsp_word
);
   import mfb_pkg::*;

   logic [7:0] mem [0:STORE_BYTES-1];

   req_type           req_ff;
   logic              in_range_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [2:0]        bit_ff;
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic              fill_ff;
   logic              xor_mode_ff;
   logic              reverse_mode_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              in_range;
   logic [PIX_W-1:0]  pix_in;
   logic [ADDR_W-1:0] rd_addr;
   logic              cur_bit;
   logic              new_bit;
   logic [7:0]        new_byte;
   logic              is_get;
   logic              is_set;
   logic              pix_we;
   rsp_type           rsp_in;

   assign in_range = (32'(req_word.column) < SCREEN_WIDTH)
                  && (32'(req_word.row) < SCREEN_HEIGHT);
   assign pix_in   = PIX_W'(32'(req_word.row) * SCREEN_WIDTH + 32'(req_word.column));
   // Park the read address at zero for coordinates off the screen.
   assign rd_addr  = in_range ? pix_in[PIX_W-1:3] : '0;

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         req_ff      <= req_word;
         in_range_ff <= in_range;
         addr_ff     <= rd_addr;
         bit_ff      <= pix_in[2:0];
         rd_data_ff  <= mem[rd_addr];
      end
   end

   assign is_get  = (req_ff.opcode == OP_GET);
   assign is_set  = (req_ff.opcode == OP_SET);
   // First pixel of a byte is its MSB.
   assign cur_bit = rd_data_ff[~bit_ff];
   assign new_bit = (req_ff.pixel_value ^ (xor_mode_ff & cur_bit)) ^ reverse_mode_ff;
   assign pix_we  = cmd_i.commit && is_set && in_range_ff;

   always_comb begin
      new_byte          = rd_data_ff;
      new_byte[~bit_ff] = new_bit;
   end

   always_ff @(posedge clock) begin
      if (cmd_i.sweep_step) begin
         mem[sweep_ff] <= {8{fill_ff}};
      end else if (pix_we) begin
         mem[addr_ff] <= new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         fill_ff  <= 1'b0;
      end else if (cmd_i.sweep_load) begin
         sweep_ff <= '0;
         fill_ff  <= req_word.pixel_value;
      end else if (cmd_i.sweep_step) begin
         sweep_ff <= status_o.sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   assign status_o.sweep_last   = (32'(sweep_ff) == STORE_BYTES - 1);
   assign status_o.req_is_clear = (req_word.opcode == OP_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_mode_ff     <= 1'b0;
         reverse_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_XOR_MODE:     xor_mode_ff     <= csr_data;
            CSR_REVERSE_MODE: reverse_mode_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   always_comb begin
      rsp_in = '0;
      if (!cmd_i.sweep_done) begin
         rsp_in.status     = !(in_range_ff && (is_get || is_set));
         rsp_in.pixel_read = is_get && in_range_ff && cur_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_i.commit | cmd_i.sweep_done;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* design/monochrome_framebuffer_pixel_ops.sv */
// Top level of the one-bit packed frame store with get, set and clear operations.
//
// A command is taken when start is high and busy is low. For get and set, the byte is
// read from the single-port store in the accept cycle and the result (and, for set, the
// write-back of the modified byte) follows in the next cycle; the result word shows on
// rsp_word for one cycle with rsp_valid, the cycle after that, and cannot be stalled.
// Clear occupies the store's one write port after the accept cycle while it walks all
// STORE_BYTES bytes (860 at 160 x 43), one byte per cycle. After reset the block runs
// the same walk to zero the store and stays busy until it is done; register writes on
// the csr port are always ready.
module monochrome_framebuffer_pixel_ops (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mfb_pkg::req_type               req_word,
   output logic                           rsp_valid,
   output mfb_pkg::rsp_type               rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                           csr_data
);
   import mfb_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   mfb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .status_i (status),
      .cmd_o    (cmd),
      .busy     (busy)
   );

   mfb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd_i     (cmd),
      .status_o  (status),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* design/mfb_checker.sv */
// Port-level checker for the frame store, bound to the top level.
module mfb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input mfb_pkg::req_type               req_word,
   input logic                           rsp_valid,
   input mfb_pkg::rsp_type               rsp_word
);
   import mfb_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // Get/set: busy for one cycle, then the word shows with the block free again.
   a_access_timing: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.opcode != OP_CLEAR) |=> busy ##1 (rsp_valid && !busy))
      else $error("get/set word not delivered two cycles after accept");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.opcode == OP_CLEAR) |=> busy && !rsp_valid)
      else $error("clear did not hold the block busy");

   a_no_double_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result words in consecutive cycles");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status |-> !rsp_word.pixel_read)
      else $error("error word carries a pixel bit");

endmodule

bind monochrome_framebuffer_pixel_ops mfb_checker u_mfb_checker (.*);
